/* hw/rtl/dof_pkg.sv */
// Constants, register map and fixed-point helpers for the disturbance observer filter.
package dof_pkg;

   // register map: word index taken from paddr[4:2]
   localparam int CsrAddrW = 5;
   localparam logic [2:0] RegEnable    = 3'd0;
   localparam logic [2:0] RegAGain     = 3'd1;
   localparam logic [2:0] RegAPole1    = 3'd2;
   localparam logic [2:0] RegAPole2    = 3'd3;
   localparam logic [2:0] RegBGain     = 3'd4;
   localparam logic [2:0] RegBPole     = 3'd5;

   localparam int CoefW   = 32;
   localparam int AccW    = 48;   // Q32.16 filter state
   localparam int PoleW   = 51;   // rounded pole product, Q32.16
   localparam int GainInW = 25;   // widest gain multiplicand (position difference)
   localparam int GainW   = 53;   // rounded gain product, Q32.16
   localparam int SumW    = 56;   // filter sum before saturation
   localparam int DiffW   = 49;   // w - v

   localparam logic signed [SumW-1:0] AccMax = 56'sh00_7FFF_FFFF_FFFF;
   localparam logic signed [SumW-1:0] AccMin = -56'sh00_8000_0000_0000;

   // 15000 mA in Q32.16
   localparam logic signed [DiffW-1:0] LimitQ   = 49'sd983040000;
   localparam logic signed [31:0]      HalfLsb  = 32'sd32768;
   localparam logic signed [57:0]      PoleRnd  = 58'sd536870912;
   localparam logic signed [56:0]      GainRnd  = 57'sd8;

   // Q2.30 pole times Q32.16 value, rounded to nearest (ties up) in Q32.16.
   // The 48-bit operand is split at bit 24 so the multipliers are 32x24 and 32x25.
   function automatic logic signed [PoleW-1:0] pole_mul(input logic signed [CoefW-1:0] c,
                                                       input logic signed [AccW-1:0] x);
      logic signed [23:0] wh;
      logic signed [24:0] wl;
      logic signed [55:0] hi;
      logic signed [56:0] lo;
      logic signed [49:0] hq;
      logic signed [57:0] rest;
      wh   = x[47:24];
      wl   = $signed({1'b0, x[23:0]});
      hi   = c * wh;
      lo   = c * wl;
      hq   = hi[55:6];
      rest = $signed({28'd0, hi[5:0], 24'd0}) + 58'(lo) + PoleRnd;
      return PoleW'(hq) + PoleW'($signed(rest[57:30]));
   endfunction

   // Q12.20 gain times an integer, rounded to Q32.16
   function automatic logic signed [GainW-1:0] gain_mul(input logic signed [CoefW-1:0] g,
                                                       input logic signed [GainInW-1:0] x);
      logic signed [56:0] p;
      p = g * x;
      p = p + GainRnd;
      return p[56:4];
   endfunction

   function automatic logic signed [AccW-1:0] sat48(input logic signed [SumW-1:0] x);
      logic signed [AccW-1:0] r;
      if (x > AccMax) begin
         r = AccMax[AccW-1:0];
      end else if (x < AccMin) begin
         r = AccMin[AccW-1:0];
      end else begin
         r = x[AccW-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/disturbance_observer_filter.sv */
// Disturbance observer: control-input low-pass and position band-pass, output w - v clamped.
//
// Usage: each req transaction carries a control current (mA), a position sample and a
// clear flag; each one yields exactly one rsp transaction with the disturbance estimate
// in whole mA, clamped to +/-15000. Coefficients and enable sit in an APB register file
// (psel/penable/pwrite/paddr/pwdata/prdata/pready), word i at byte address 4*i; pready
// is tied high. Write registers only while no transaction is in flight.
// Each accepted req is captured in the input register and then loaded into the result
// register, where rsp_valid goes high; rsp_stall can hold it in the input register first
// (input register, then result register). Throughput: one transaction per cycle while
// rsp_stall is low; the filter recursion closes combinationally from the input register
// to the result register, through the pole and gain multipliers and saturating adders.
// Reset clears all filter history, the registers (enable=0) and both valid flags.
// When rsp_stall is high the result holds; the input register still takes one more
// transaction, after which req_stall rises until the result is taken.
// clear=1 zeroes the history and returns 0; with enable=0 the output is 0 and history
// is left as it was.
module disturbance_observer_filter
   import dof_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [15:0]        req_control_current,
   input  logic signed [23:0]        req_position,
   input  logic                      req_clear,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [14:0]        rsp_disturbance,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CsrAddrW-1:0]       paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // ---------------- registers ----------------
   logic                     enable_ff;
   logic signed [CoefW-1:0]  a_gain_ff, a_pole1_ff, a_pole2_ff, b_gain_ff, b_pole_ff;
   logic                     csr_wr;
   logic [2:0]               csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         a_gain_ff  <= '0;
         a_pole1_ff <= '0;
         a_pole2_ff <= '0;
         b_gain_ff  <= '0;
         b_pole_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            RegEnable: enable_ff  <= pwdata[0];
            RegAGain:  a_gain_ff  <= $signed(pwdata);
            RegAPole1: a_pole1_ff <= $signed(pwdata);
            RegAPole2: a_pole2_ff <= $signed(pwdata);
            RegBGain:  b_gain_ff  <= $signed(pwdata);
            RegBPole:  b_pole_ff  <= $signed(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         RegEnable: prdata = {31'd0, enable_ff};
         RegAGain:  prdata = a_gain_ff;
         RegAPole1: prdata = a_pole1_ff;
         RegAPole2: prdata = a_pole2_ff;
         RegBGain:  prdata = b_gain_ff;
         RegBPole:  prdata = b_pole_ff;
         default:   prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic               s1_valid_ff;
   logic signed [15:0] s1_u_ff;
   logic signed [23:0] s1_y_ff;
   logic               s1_clr_ff;
   logic               rsp_valid_ff;
   logic signed [14:0] rsp_dist_ff;
   logic               advance;
   logic               s1_fire;
   logic               req_take;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire   = s1_valid_ff & advance;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_u_ff   <= req_control_current;
         s1_y_ff   <= req_position;
         s1_clr_ff <= req_clear;
      end
   end

   // ---------------- filter datapath ----------------
   logic signed [AccW-1:0]  lp1_ff, lp2_ff, bp_ff;
   logic signed [15:0]      cp1_ff, cp2_ff;
   logic signed [23:0]      yp_ff;

   logic signed [17:0]      u_sum;
   logic signed [24:0]      y_diff;
   logic signed [PoleW-1:0] a1_term, a2_term, b1_term;
   logic signed [GainW-1:0] ga_term, gb_term;
   logic signed [SumW-1:0]  w_sum, v_sum;
   logic signed [AccW-1:0]  w_in, v_in;
   logic signed [DiffW-1:0] d_raw, d_clamp;
   logic signed [31:0]      d_rnd;
   logic signed [14:0]      dist_in;

   always_comb begin
      u_sum   = 18'(s1_u_ff) + (18'(cp1_ff) <<< 1) + 18'(cp2_ff);
      y_diff  = 25'(s1_y_ff) - 25'(yp_ff);
      a1_term = pole_mul(a_pole1_ff, lp1_ff);
      a2_term = pole_mul(a_pole2_ff, lp2_ff);
      b1_term = pole_mul(b_pole_ff, bp_ff);
      ga_term = gain_mul(a_gain_ff, GainInW'(u_sum));
      gb_term = gain_mul(b_gain_ff, y_diff);
      w_sum   = SumW'(a1_term) - SumW'(a2_term) + SumW'(ga_term);
      v_sum   = SumW'(b1_term) + SumW'(gb_term);
      w_in    = sat48(w_sum);
      v_in    = sat48(v_sum);
      d_raw   = DiffW'(w_in) - DiffW'(v_in);
      priority if (d_raw > LimitQ) begin
         d_clamp = LimitQ;
      end else if (d_raw < -LimitQ) begin
         d_clamp = -LimitQ;
      end else begin
         d_clamp = d_raw;
      end
      // |d_clamp| < 2^30, so the rounded value sits in bits 30:16
      d_rnd = 32'(d_clamp) + HalfLsb;
      if (s1_clr_ff || !enable_ff) begin
         dist_in = '0;
      end else begin
         dist_in = d_rnd[30:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp1_ff <= '0;
         lp2_ff <= '0;
         bp_ff  <= '0;
         cp1_ff <= '0;
         cp2_ff <= '0;
         yp_ff  <= '0;
      end else if (s1_fire) begin
         if (s1_clr_ff) begin
            lp1_ff <= '0;
            lp2_ff <= '0;
            bp_ff  <= '0;
            cp1_ff <= '0;
            cp2_ff <= '0;
            yp_ff  <= '0;
         end else if (enable_ff) begin
            lp2_ff <= lp1_ff;
            lp1_ff <= w_in;
            bp_ff  <= v_in;
            cp2_ff <= cp1_ff;
            cp1_ff <= s1_u_ff;
            yp_ff  <= s1_y_ff;
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_disturbance = rsp_dist_ff;

   // ---------------- assertions ----------------
   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_disturbance <= 15'sd15000) && (rsp_disturbance >= -15'sd15000))
      else $error("disturbance outside clamp range");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_clr_ff |=> (lp1_ff == '0) && (lp2_ff == '0) && (bp_ff == '0)
                               && (rsp_disturbance == '0))
      else $error("clear did not zero history and output");

   a_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_clr_ff && !enable_ff |=> $stable(lp1_ff) && $stable(bp_ff)
                                             && $stable(yp_ff) && (rsp_disturbance == '0))
      else $error("disabled observer changed history or output");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("req_stall without a held transaction");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid)
      else $error("transaction lost between input and result register");

endmodule

/* test/disturbance_observer_filter_tb.sv */
// Self-checking testbench for the disturbance observer filter: directed and random samples.
`timescale 1ns / 100ps

module disturbance_observer_filter_tb
   import dof_pkg::*;
();

   typedef logic signed [127:0] wide_type;
   typedef enum int {IdleNone, IdleLight, IdleHeavy} idle_type;

   localparam logic [2:0] RegSpareLo = 3'd6;
   localparam logic [2:0] RegSpareHi = 3'd7;

   // nominal coefficients: poles at r = 0.9, unity DC gain on the current path
   localparam logic [31:0] NomAGain  = 32'd2621;
   localparam logic [31:0] NomAPole1 = 32'd1932735283;
   localparam logic [31:0] NomAPole2 = 32'd869730877;
   localparam logic [31:0] NomBGain  = 32'd524288;
   localparam logic [31:0] NomBPole  = 32'd966367642;
   localparam logic [31:0] CoefMax   = 32'h7FFF_FFFF;
   localparam logic [31:0] CoefMin   = 32'h8000_0000;

   localparam wide_type PoleHalf = 128'sh2000_0000;
   localparam wide_type GainHalf = 128'sd8;
   localparam wide_type MaHalf   = 128'sd32768;
   localparam wide_type Q48Max   = 128'sh7FFF_FFFF_FFFF;
   localparam wide_type Q48Min   = -128'sh8000_0000_0000;
   localparam wide_type ClampQ   = 128'sd983040000;

   class observer_model;
      logic               enable;
      logic signed [31:0] a_gain, a_pole1, a_pole2, b_gain, b_pole;
      wide_type           lp1, lp2, bp;
      logic signed [15:0] cur1, cur2;
      logic signed [23:0] pos1;
      logic signed [14:0] expected[$];
      int                 errors;

      function new();
         enable = 1'b0;
         a_gain = '0;
         a_pole1 = '0;
         a_pole2 = '0;
         b_gain = '0;
         b_pole = '0;
         errors = 0;
         clear_history();
      endfunction

      function void clear_history();
         lp1 = '0;
         lp2 = '0;
         bp = '0;
         cur1 = '0;
         cur2 = '0;
         pos1 = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            RegEnable: enable = val[0];
            RegAGain:  a_gain = val;
            RegAPole1: a_pole1 = val;
            RegAPole2: a_pole2 = val;
            RegBGain:  b_gain = val;
            RegBPole:  b_pole = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            RegEnable: return {31'd0, enable};
            RegAGain:  return a_gain;
            RegAPole1: return a_pole1;
            RegAPole2: return a_pole2;
            RegBGain:  return b_gain;
            RegBPole:  return b_pole;
            default:   return '0;
         endcase
      endfunction

      // Q2.30 times Q32.16, nearest with ties up
      function wide_type pole_term(logic signed [31:0] c, wide_type x);
         wide_type p;
         p = c;
         return (p * x + PoleHalf) >>> 30;
      endfunction

      // Q12.20 times integer, into Q32.16
      function wide_type gain_term(logic signed [31:0] g, wide_type x);
         wide_type p;
         p = g;
         return (p * x + GainHalf) >>> 4;
      endfunction

      function wide_type clip(wide_type x, wide_type lo, wide_type hi);
         if (x > hi) return hi;
         if (x < lo) return lo;
         return x;
      endfunction

      function void take_sample(logic signed [15:0] cur, logic signed [23:0] pos, logic clr);
         wide_type u, u1, u2, y, y1, w, v, d, r;
         if (clr) begin
            clear_history();
            expected.push_back('0);
            return;
         end
         if (!enable) begin
            expected.push_back('0);
            return;
         end
         u = cur;
         u1 = cur1;
         u2 = cur2;
         y = pos;
         y1 = pos1;
         w = pole_term(a_pole1, lp1) - pole_term(a_pole2, lp2) + gain_term(a_gain, u + 2 * u1 + u2);
         w = clip(w, Q48Min, Q48Max);
         v = pole_term(b_pole, bp) + gain_term(b_gain, y - y1);
         v = clip(v, Q48Min, Q48Max);
         lp2 = lp1;
         lp1 = w;
         cur2 = cur1;
         cur1 = cur;
         bp = v;
         pos1 = pos;
         d = clip(w - v, -ClampQ, ClampQ);
         r = (d + MaHalf) >>> 16;
         expected.push_back(r[14:0]);
      endfunction

      function void check_estimate(logic signed [14:0] got);
         logic signed [14:0] want;
         if (expected.size() == 0) begin
            $display("%0t: disturbance expected none actual %0d", $time, got);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (got !== want) begin
            $display("%0t: disturbance expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_control_current = '0;
   logic signed [23:0] req_position = '0;
   logic req_clear = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [14:0] rsp_disturbance;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   observer_model dob = new();
   idle_type idle_style = IdleHeavy;
   int hold_off = 0;
   logic signed [23:0] walk_pos = '0;

   disturbance_observer_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_control_current(req_control_current),
      .req_position(req_position),
      .req_clear(req_clear),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_disturbance(rsp_disturbance),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready) dob.write_reg(paddr[4:2], pwdata);
         if (req_valid && !req_stall) begin
            dob.take_sample(req_control_current, req_position, req_clear);
         end
         if (rsp_valid && !rsp_stall) dob.check_estimate(rsp_disturbance);
      end
   end

   function automatic int draw_wait();
      case (idle_style)
         IdleNone:  return 0;
         IdleLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
         default:   return $urandom_range(0, 16);
      endcase
   endfunction

   function automatic logic [31:0] pick_pole();
      case ($urandom_range(0, 2))
         0:       return CoefMax;
         1:       return CoefMin;
         default: return $urandom;
      endcase
   endfunction

   // one APB transfer: setup, access, then a return to bus idle
   task automatic csr_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                            output logic [31:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] rd;
      csr_cycle(1'b1, idx, val, rd);
      if (idx <= RegBPole) begin
         csr_cycle(1'b0, idx, '0, rd);
         if (rd !== dob.reg_value(idx)) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx,
                     dob.reg_value(idx), rd);
            dob.errors++;
         end
      end
   endtask

   task automatic program_filter(input logic [31:0] en, input logic [31:0] ga, p1, p2, gb, pb);
      set_reg(RegAGain, ga);
      set_reg(RegAPole1, p1);
      set_reg(RegAPole2, p2);
      set_reg(RegBGain, gb);
      set_reg(RegBPole, pb);
      set_reg(RegEnable, en);
   endtask

   task automatic offer(input logic signed [15:0] cur, input logic signed [23:0] pos,
                        input logic clr);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_control_current <= cur;
      req_position <= pos;
      req_clear <= clr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding estimate
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dob.expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side back-pressure
   initial begin
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         n = hold_off;
         hold_off = 0;
         if (n == 0) n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL disturbance_observer_filter");
      $finish;
   end

   initial begin
      int phase, i, step;
      logic signed [15:0] cur;
      logic clr;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: observer off
      offer(16'sd1000, 24'sd5000, 1'b0);
      drain();

      program_filter(32'd1, NomAGain, NomAPole1, NomAPole2, NomBGain, NomBPole);
      offer(16'sh7FFF, 24'sh7FFFFF, 1'b0);
      offer(16'sh7FFF, 24'sh7FFFFF, 1'b0);
      offer(-16'sh8000, -24'sh800000, 1'b0);
      offer(-16'sh8000, -24'sh800000, 1'b0);
      offer(16'sd0, 24'sd0, 1'b0);
      offer(-16'sh8000, 24'sh7FFFFF, 1'b1);
      offer(16'sd500, 24'sd100, 1'b0);
      offer(16'sd500, 24'sd120, 1'b0);
      drain();

      // disabled: zero output, history kept across the gap
      set_reg(RegEnable, 32'd0);
      offer(16'sd20000, -24'sd300000, 1'b0);
      offer(-16'sd1, 24'sd1, 1'b0);
      drain();
      set_reg(RegEnable, 32'hFFFF_FFFF);
      offer(16'sd300, 24'sd50, 1'b0);
      drain();
      set_reg(RegEnable, 32'd0);
      offer(16'sd7, 24'sd7, 1'b1);
      drain();
      set_reg(RegEnable, 32'd1);
      offer(16'sd300, 24'sd60, 1'b0);
      offer(16'sd300, 24'sd70, 1'b0);
      drain();

      // coefficient extremes drive the accumulators into saturation
      program_filter(32'd1, CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
      offer(16'sh7FFF, -24'sh800000, 1'b0);
      offer(16'sh7FFF, 24'sh7FFFFF, 1'b0);
      offer(16'sh7FFF, -24'sh800000, 1'b0);
      drain();
      program_filter(32'd1, CoefMin, CoefMin, CoefMin, CoefMin, CoefMin);
      offer(-16'sh8000, 24'sh7FFFFF, 1'b0);
      offer(-16'sh8000, 24'sh7FFFFF, 1'b0);
      offer(16'sh7FFF, -24'sh800000, 1'b0);
      offer(16'sd0, 24'sd0, 1'b1);
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: program_filter($urandom | 32'd1, NomAGain + 32'($urandom_range(0, 3000)),
                              NomAPole1 - 32'($urandom_range(0, 100000000)),
                              NomAPole2 + 32'($urandom_range(0, 50000000)),
                              32'($urandom_range(1000, 600000)),
                              NomBPole - 32'($urandom_range(0, 200000000)));
            1: program_filter(32'd1, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: program_filter(32'd1, NomAGain, pick_pole(), pick_pole(), NomBGain,
                                    pick_pole());
         endcase
         if (phase == 2) begin
            set_reg(RegSpareLo, $urandom);
            set_reg(RegSpareHi, $urandom);
         end
         for (i = 0; i < 130; i++) begin
            if (i % 40 == 0) idle_style = idle_type'($urandom_range(0, 2));
            if (phase == 1 && i == 30) begin
               // long receiver hold while samples keep coming
               idle_style = IdleNone;
               hold_off = 400;
            end
            if (phase == 4 && i == 100) drain();
            if ($urandom_range(0, 7) == 0) begin
               cur = 16'($urandom);
            end else begin
               step = $urandom_range(0, 4000);
               cur = 16'(step - 2000);
            end
            if ($urandom_range(0, 7) == 0) begin
               walk_pos = 24'($urandom);
            end else begin
               step = $urandom_range(0, 2000);
               walk_pos = walk_pos + 24'(step - 1000);
            end
            clr = ($urandom_range(0, 39) == 0);
            offer(cur, walk_pos, clr);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (dob.errors == 0) begin
         $display("PASS disturbance_observer_filter");
      end else begin
         $display("FAIL disturbance_observer_filter");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dof_pkg.sv
hw/rtl/disturbance_observer_filter.sv
test/disturbance_observer_filter_tb.sv
